### rtl/olee_pkg.sv
// Shared constants, types and helpers of the ordered list edit engine.
`default_nettype none

package olee_pkg;

  localparam int DEPTH = 16;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_DELFRONT = 3'd1,
    OP_DELLAST  = 3'd2,
    OP_DELALL   = 3'd3,
    OP_INSERT   = 3'd4,
    OP_REVERSE  = 3'd5,
    OP_SWAP     = 3'd6,
    OP_DUMP     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // hold; left: below p take right neighbor, p loads; right: above p take
  // left neighbor, p loads; load: p and q load their own words
  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LEFT  = 2'd1,
    CM_RIGHT = 2'd2,
    CM_LOAD  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    idx_t       p;
    idx_t       q;
    logic       ld0;
    logic       ld1;
    word_t      v0;
    word_t      v1;
  } cell_ctl_t;

  function automatic logic [4:0] count5(input cnt_t c);
    logic [31:0] e;
    e = 32'(c);
    return e[4:0];
  endfunction

endpackage

`default_nettype wire

### rtl/olee_cell.sv
// One list cell: holds a word, loads from a neighbor or a broadcast word.
`default_nettype none

module olee_cell (
  input  wire logic              clk,
  input  wire olee_pkg::cell_ctl_t ctl,
  input  wire olee_pkg::idx_t    cell_idx,
  input  wire olee_pkg::word_t   left_val,
  input  wire olee_pkg::word_t   right_val,
  output      olee_pkg::word_t   val
);
  import olee_pkg::*;

  word_t val_r;
  word_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.mode)
      CM_LEFT: begin
        if (cell_idx < ctl.p) val_nxt = right_val;
        else if (cell_idx == ctl.p && ctl.ld0) val_nxt = ctl.v0;
      end
      CM_RIGHT: begin
        if (cell_idx > ctl.p) val_nxt = left_val;
        else if (cell_idx == ctl.p && ctl.ld0) val_nxt = ctl.v0;
      end
      CM_LOAD: begin
        if (cell_idx == ctl.p && ctl.ld0) val_nxt = ctl.v0;
        else if (cell_idx == ctl.q && ctl.ld1) val_nxt = ctl.v1;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

### rtl/olee_chain.sv
// Row of DEPTH list cells, front entry at cell 0.
`default_nettype none

module olee_chain (
  input  wire logic              clk,
  input  wire olee_pkg::cell_ctl_t ctl,
  output      olee_pkg::word_t   head_val
);
  import olee_pkg::*;

  word_t cell_val [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lv;
    word_t rv;
    if (i == 0) begin : g_first
      assign lv = cell_val[i];
    end else begin : g_mid_l
      assign lv = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_mid_r
      assign rv = cell_val[i+1];
    end
    olee_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IW'(i)),
      .left_val (lv),
      .right_val(rv),
      .val      (cell_val[i])
    );
  end

  assign head_val = cell_val[0];

endmodule

`default_nettype wire

### rtl/ordered_list_edit_engine_core.sv
// Ordered list edit engine: sequencer, output register and cell row.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | operation, value_x, value_y
//  out_    | output    | out_valid / out_stall| status, entry_value, is_dump_entry,
//          |           |                      | list_empty, last_result, entry_count
//
// Append, delete front and delete last go from idle straight to finish. The
// other operations rotate the list once through cell 0, one entry a cycle
// unless a dump step waits; dump emits one word per rotation step and waits
// there while out_stall holds a full output register. Reset empties the list.
`default_nettype none

module ordered_list_edit_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic signed [31:0] in_value_x,
  input  wire logic signed [31:0] in_value_y,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_status,
  output      logic signed [31:0] out_entry_value,
  output      logic        out_is_dump_entry,
  output      logic        out_list_empty,
  output      logic        out_last_result,
  output      logic [4:0]  out_entry_count
);
  import olee_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t    state_r, state_nxt;
  cnt_t      len_r, len_nxt;
  cnt_t      r_r, r_nxt;
  cnt_t      k_r, k_nxt;
  op_t       op_r, op_nxt;
  word_t     x_r, x_nxt;
  word_t     y_r, y_nxt;
  logic      fx_r, fx_nxt;
  logic      fy_r, fy_nxt;
  logic      drop_r, drop_nxt;
  idx_t      px_r, px_nxt;
  idx_t      py_r, py_nxt;

  logic      out_valid_r;
  status_t   out_status_r;
  word_t     out_value_r;
  logic      out_dump_r;
  logic      out_empty_r;
  logic      out_last_r;
  logic [4:0] out_count_r;

  logic      emit;
  status_t   e_status;
  word_t     e_value;
  logic      e_dump;
  logic      e_empty;
  logic      e_last;
  cnt_t      e_count;

  cell_ctl_t ctl;
  word_t     head;
  logic      mx, my, out_free, full;
  cnt_t      rk, rm1;

  olee_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .head_val(head)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign mx       = (head == x_r);
  assign my       = (head == y_r);
  assign rm1      = r_r - CW'(1);
  assign rk       = rm1 + k_r;
  assign full     = (len_r == CW'(DEPTH));
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    drop_nxt  = drop_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ctl       = '0;
    ctl.mode  = CM_HOLD;
    emit      = 1'b0;
    e_status  = ST_DONE;
    e_value   = '0;
    e_dump    = 1'b0;
    e_empty   = 1'b0;
    e_last    = 1'b1;
    e_count   = len_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_operation);
          x_nxt    = in_value_x;
          y_nxt    = in_value_y;
          r_nxt    = len_r;
          k_nxt    = '0;
          fx_nxt   = 1'b0;
          fy_nxt   = 1'b0;
          drop_nxt = 1'b0;
          if (op_t'(in_operation) == OP_APPEND || op_t'(in_operation) == OP_DELFRONT ||
              op_t'(in_operation) == OP_DELLAST) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (r_r == '0) begin
          state_nxt = S_FIN;
        end else if (op_r != OP_DUMP || out_free) begin
          r_nxt    = rm1;
          ctl.mode = CM_LEFT;
          ctl.v0   = head;
          case (op_r)
            OP_DELALL: begin
              ctl.p    = rk[IW-1:0];
              ctl.ld0  = ~mx;
              k_nxt    = k_r + {{(CW-1){1'b0}}, ~mx};
              drop_nxt = drop_r | mx;
            end
            OP_REVERSE: begin
              // front word goes right behind the words not yet moved
              ctl.p   = rm1[IW-1:0];
              ctl.ld0 = 1'b1;
            end
            default: begin
              // plain rotation: front word back to the tail
              ctl.p   = rk[IW-1:0];
              ctl.ld0 = 1'b1;
              k_nxt   = k_r + CW'(1);
              if (mx && !fx_r) begin
                fx_nxt = 1'b1;
                px_nxt = k_r[IW-1:0];
              end
              if (my && !fy_r) begin
                fy_nxt = 1'b1;
                py_nxt = k_r[IW-1:0];
              end
              if (op_r == OP_DUMP) begin
                emit    = 1'b1;
                e_value = head;
                e_dump  = 1'b1;
                e_last  = (r_r == CW'(1));
              end
            end
          endcase
        end
      end
      S_FIN: begin
        if (op_r == OP_DUMP && len_r != '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          case (op_r)
            OP_APPEND: begin
              if (full) begin
                e_status = ST_FULL;
              end else begin
                ctl.mode = CM_LOAD;
                ctl.p    = len_r[IW-1:0];
                ctl.ld0  = 1'b1;
                ctl.v0   = x_r;
                len_nxt  = len_r + CW'(1);
              end
            end
            OP_DELFRONT: begin
              if (len_r == '0) begin
                e_status = ST_NOCHANGE;
              end else begin
                ctl.mode = CM_LEFT;
                ctl.p    = IW'(len_r - CW'(1));
                len_nxt  = len_r - CW'(1);
              end
            end
            OP_DELLAST: begin
              if (len_r == '0) e_status = ST_NOCHANGE;
              else len_nxt = len_r - CW'(1);
            end
            OP_DELALL: begin
              if (!drop_r) e_status = ST_NOCHANGE;
              len_nxt = k_r;
            end
            OP_INSERT: begin
              if (!fx_r) begin
                e_status = ST_NOCHANGE;
              end else if (full) begin
                e_status = ST_FULL;
              end else begin
                ctl.mode = CM_RIGHT;
                ctl.p    = px_r + IW'(1);
                ctl.ld0  = 1'b1;
                ctl.v0   = y_r;
                len_nxt  = len_r + CW'(1);
              end
            end
            OP_REVERSE: begin
              if (len_r == '0) e_status = ST_NOCHANGE;
            end
            OP_SWAP: begin
              if (fx_r && fy_r) begin
                ctl.mode = CM_LOAD;
                ctl.p    = px_r;
                ctl.ld0  = 1'b1;
                ctl.v0   = y_r;
                ctl.q    = py_r;
                ctl.ld1  = 1'b1;
                ctl.v1   = x_r;
              end else begin
                e_status = ST_NOCHANGE;
              end
            end
            default: begin
              // dump of an empty list
              e_status = ST_NOCHANGE;
              e_empty  = 1'b1;
            end
          endcase
          e_count = len_nxt;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    op_r   <= op_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    fx_r   <= fx_nxt;
    fy_r   <= fy_nxt;
    drop_r <= drop_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_value_r  <= e_value;
      out_dump_r   <= e_dump;
      out_empty_r  <= e_empty;
      out_last_r   <= e_last;
      out_count_r  <= count5(e_count);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_value   = out_value_r;
  assign out_is_dump_entry = out_dump_r;
  assign out_list_empty    = out_empty_r;
  assign out_last_result   = out_last_r;
  assign out_entry_count   = out_count_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CW'(DEPTH))
    else $error("list length above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted word did not start work");

  a_len_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_FIN |=> $stable(len_r))
    else $error("length changed outside finish step");

  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> ({1'b0, k_r} + {1'b0, r_r}) <= {1'b0, len_r})
    else $error("rotation counters exceed list length");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for ordered_list_edit_engine_core: directed and random list edits, self-checking.
`timescale 1ns / 1ps

import olee_pkg::*;

typedef struct packed {
  status_t    status;
  word_t      value;
  logic       dump;
  logic       empty;
  logic       last;
  logic [4:0] count;
} list_word_t;

class list_scoreboard;
  word_t      entries[DEPTH];
  int         length;
  list_word_t pending[$];
  int         mismatches;

  function int find_first(word_t v);
    for (int i = 0; i < length; i++)
      if (entries[i] === v) return i;
    return -1;
  endfunction

  function void push_word(status_t st, word_t v, logic d, logic e, logic l);
    list_word_t w;
    w.status = st;
    w.value  = v;
    w.dump   = d;
    w.empty  = e;
    w.last   = l;
    w.count  = 5'(length);
    pending.push_back(w);
  endfunction

  // Apply one accepted input word to the list copy and queue its results.
  function void note_word(op_t op, word_t x, word_t y);
    status_t st;
    int      j;
    int      px;
    int      py;
    word_t   t;
    st = ST_DONE;
    case (op)
      OP_APPEND: begin
        if (length >= DEPTH) st = ST_FULL;
        else begin
          entries[length] = x;
          length++;
        end
      end
      OP_DELFRONT: begin
        if (length == 0) st = ST_NOCHANGE;
        else begin
          for (int i = 1; i < length; i++) entries[i-1] = entries[i];
          length--;
        end
      end
      OP_DELLAST: begin
        if (length == 0) st = ST_NOCHANGE;
        else length--;
      end
      OP_DELALL: begin
        j = 0;
        for (int i = 0; i < length; i++)
          if (entries[i] !== x) begin
            entries[j] = entries[i];
            j++;
          end
        if (j == length) st = ST_NOCHANGE;
        length = j;
      end
      OP_INSERT: begin
        px = find_first(x);
        if (px < 0) st = ST_NOCHANGE;
        else if (length >= DEPTH) st = ST_FULL;
        else begin
          for (int i = length; i > px + 1; i--) entries[i] = entries[i-1];
          entries[px+1] = y;
          length++;
        end
      end
      OP_REVERSE: begin
        if (length == 0) st = ST_NOCHANGE;
        else begin
          for (int i = 0; i < length - 1 - i; i++) begin
            t = entries[i];
            entries[i] = entries[length-1-i];
            entries[length-1-i] = t;
          end
        end
      end
      OP_SWAP: begin
        px = find_first(x);
        py = find_first(y);
        if (px < 0 || py < 0) st = ST_NOCHANGE;
        else begin
          entries[px] = y;
          entries[py] = x;
        end
      end
      default: begin
        if (length == 0) push_word(ST_NOCHANGE, '0, 1'b0, 1'b1, 1'b1);
        for (int i = 0; i < length; i++)
          push_word(ST_DONE, entries[i], 1'b1, 1'b0, (i == length - 1));
        return;
      end
    endcase
    push_word(st, '0, 1'b0, 1'b0, 1'b1);
  endfunction

  function void check_word(list_word_t got);
    list_word_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: status %0d value %0d dump %0b empty %0b last %0b count %0d",
                 got.status, got.value, got.dump, got.empty, got.last, got.count);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected status %0d value %0d dump %0b empty %0b last %0b count %0d",
                 want.status, want.value, want.dump, want.empty, want.last, want.count);
        $display("          actual   status %0d value %0d dump %0b empty %0b last %0b count %0d",
                 got.status, got.value, got.dump, got.empty, got.last, got.count);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int RANDOM_WORDS = 106;

  localparam word_t VAL_MIN = 32'sh8000_0000;
  localparam word_t VAL_MAX = 32'sh7fff_ffff;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  word_t       in_value_x;
  word_t       in_value_y;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  word_t       out_entry_value;
  logic        out_is_dump_entry;
  logic        out_list_empty;
  logic        out_last_result;
  logic [4:0]  out_entry_count;

  list_scoreboard sb = new;

  int         accepted;
  bit         quiet;
  int         idle_pct;
  int         stall_left;
  int         rx_cycle;
  bit         long_hold_done;
  list_word_t rx_word;

  ordered_list_edit_engine_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_value_x        (in_value_x),
    .in_value_y        (in_value_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_value   (out_entry_value),
    .out_is_dump_entry (out_is_dump_entry),
    .out_list_empty    (out_list_empty),
    .out_last_result   (out_last_result),
    .out_entry_count   (out_entry_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Send one word, optionally after an idle burst; returns once accepted.
  task automatic send_word(op_t op, word_t x, word_t y);
    int gap;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value_x   <= x;
    in_value_y   <= y;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, x, y);
    accepted++;
  endtask

  // Mostly values already in the list or corner values, so matches are common.
  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && sb.length > 0) return sb.entries[$urandom_range(0, sb.length - 1)];
    case (r)
      4: return VAL_MIN;
      5: return VAL_MAX;
      6: return word_t'($urandom_range(0, 3)) - 1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // 0: grow, 1: shrink, 2: anything
  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 55) return OP_APPEND;
        if (r < 85) return OP_INSERT;
        if (r < 95) return OP_DUMP;
      end
      1: begin
        if (r < 20) return OP_DELFRONT;
        if (r < 40) return OP_DELLAST;
        if (r < 60) return OP_DELALL;
        if (r < 75) return OP_DUMP;
        if (r < 85) return OP_REVERSE;
        if (r < 95) return OP_SWAP;
      end
      default: ;
    endcase
    return op_t'($urandom_range(0, 7));
  endfunction

  task automatic run_random();
    int   mode;
    int   left;
    int   sent;
    op_t  op;
    mode = 0;
    left = 24;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (left == 0) begin
        mode     = $urandom_range(0, 2);
        left     = $urandom_range(8, 20);
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      end
      if (sent >= RANDOM_WORDS - 25) quiet = 1'b1;
      op = pick_op(mode);
      send_word(op, pick_value(), pick_value());
      left--;
      sent++;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_DUMP;
    in_value_x   = '0;
    in_value_y   = '0;
    accepted     = 0;
    quiet        = 1'b0;
    idle_pct     = 30;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // empty list corners
    send_word(OP_DUMP, '0, '0);
    send_word(OP_DELFRONT, '0, '0);
    send_word(OP_DELLAST, '0, '0);
    send_word(OP_REVERSE, '0, '0);
    send_word(OP_DELALL, '0, '0);
    send_word(OP_INSERT, 32'sd5, 32'sd6);
    send_word(OP_SWAP, 32'sd1, 32'sd2);
    // extremes, swaps, inserts
    send_word(OP_APPEND, VAL_MIN, '0);
    send_word(OP_APPEND, VAL_MAX, '0);
    send_word(OP_REVERSE, '0, '0);
    send_word(OP_DUMP, '0, '0);
    send_word(OP_SWAP, VAL_MIN, VAL_MAX);
    send_word(OP_SWAP, VAL_MAX, VAL_MAX);
    send_word(OP_SWAP, VAL_MAX, 32'sd77);
    send_word(OP_INSERT, VAL_MAX, -32'sd1);
    send_word(OP_INSERT, 32'sd12345, 32'sd1);
    send_word(OP_DUMP, '0, '0);
    send_word(OP_DELALL, VAL_MIN, '0);
    send_word(OP_DELALL, 32'sd999, '0);
    send_word(OP_DELFRONT, '0, '0);
    send_word(OP_DELLAST, '0, '0);
    send_word(OP_APPEND, '0, '0);
    send_word(OP_REVERSE, '0, '0);
    send_word(OP_DUMP, '0, '0);

    run_random();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Result side stall: random bursts, one long hold-off to back the block up.
  always @(negedge clk) begin
    rx_cycle++;
    if (!long_hold_done && accepted >= 60) begin
      long_hold_done = 1'b1;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && (rx_cycle / 128) % 3 != 0 && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_word.status = status_t'(out_status);
      rx_word.value  = out_entry_value;
      rx_word.dump   = out_is_dump_entry;
      rx_word.empty  = out_list_empty;
      rx_word.last   = out_last_result;
      rx_word.count  = out_entry_count;
      sb.check_word(rx_word);
    end
  end

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
